// File: rtl/core/srt_pkg.sv
// shared types, widths and codes of the sorted record table
package srt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CMD_W     = 3;
    localparam int ID_W      = 31;
    localparam int KEY_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_MIN    = 3'd3,
        CMD_MAX    = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_PREV   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_NO_NEIGHBOR = 3'd3,
        ST_FULL        = 3'd4
    } status_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_WALK,
        S_INS_PUT,
        S_RM_WALK,
        S_RM_SHIFT,
        S_FIND,
        S_FETCH,
        S_DONE
    } state_e;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC,
        PTR_ZERO,
        PTR_LAST
    } ptr_op_e;

    typedef enum logic [1:0] {
        WA_PTR,
        WA_PLUS,
        WA_MINUS
    } wa_e;

    typedef enum logic {
        WS_RDATA,
        WS_NEW
    } ws_e;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ZERO,
        RES_RDATA,
        RES_PREV,
        RES_NEW
    } res_e;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_e;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } rec_t;

    typedef struct packed {
        ptr_op_e ptr_op;
        logic    wr_en;
        wa_e     wr_addr;
        ws_e     wr_src;
        res_e    res_op;
        status_e status;
        logic    prev_load;
        cnt_e    cnt_op;
        logic    cmd_load;
        logic    out_load;
    } ctl_t;

    typedef struct packed {
        cmd_e cmd;
        logic cnt_zero;
        logic cnt_full;
        logic ptr_first;
        logic ptr_last;
        logic key_lt;
        logic key_eq;
        logic id_eq;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/srt_dp.sv
// datapath of the sorted record table: record memory, walk pointer, count and result registers
module srt_dp
    import srt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [ID_W-1:0]     s_rec_id,
    input  logic [KEY_W-1:0]    s_rec_key,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [STATUS_W-1:0] m_status,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [ID_W-1:0]     m_out_id,
    output logic [CNT_W-1:0]    m_entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rec_t mem [DEPTH];

    cmd_e             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [ID_W-1:0]  id_reg;
    logic [IW-1:0]    ptr_reg;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    rec_t             wr_data;
    rec_t             rdata_reg;
    rec_t             prev_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    status_e          res_status_reg;
    rec_t             res_rec_reg;
    rec_t             res_rec_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    status_e          m_status_reg;
    rec_t             m_rec_reg;
    logic [CNT_W-1:0] m_count_reg;

    always_comb begin
        case (ctl.ptr_op)
            PTR_INC:  rd_addr = ptr_reg + IW'(1);
            PTR_DEC:  rd_addr = ptr_reg - IW'(1);
            PTR_ZERO: rd_addr = '0;
            PTR_LAST: rd_addr = IW'(count_reg - CW'(1));
            default:  rd_addr = ptr_reg;
        endcase
    end

    always_comb begin
        case (ctl.wr_addr)
            WA_PLUS:  wr_addr = ptr_reg + IW'(1);
            WA_MINUS: wr_addr = ptr_reg - IW'(1);
            default:  wr_addr = ptr_reg;
        endcase
        wr_data = (ctl.wr_src == WS_NEW) ? rec_t'{key: key_reg, id: id_reg} : rdata_reg;
    end

    always_comb begin
        case (ctl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    always_comb begin
        case (ctl.res_op)
            RES_RDATA: res_rec_next = rdata_reg;
            RES_PREV:  res_rec_next = prev_reg;
            RES_NEW:   res_rec_next = rec_t'{key: key_reg, id: id_reg};
            RES_ZERO:  res_rec_next = '0;
            default:   res_rec_next = res_rec_reg;
        endcase
        m_valid_next = ctl.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // record memory with registered read
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= rd_addr;
        if (ctl.cmd_load) begin
            cmd_reg <= cmd_e'(s_cmd);
            key_reg <= s_rec_key;
            id_reg  <= s_rec_id;
        end
        if (ctl.prev_load) begin
            prev_reg <= rdata_reg;
        end
        if (ctl.res_op != RES_HOLD) begin
            res_status_reg <= ctl.status;
        end
        res_rec_reg <= res_rec_next;
        if (ctl.out_load) begin
            m_status_reg <= res_status_reg;
            m_rec_reg    <= res_rec_reg;
            m_count_reg  <= CNT_W'(count_reg);
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.cnt_full  = (count_reg == CW'(DEPTH));
    assign sts.ptr_first = (ptr_reg == '0);
    assign sts.ptr_last  = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign sts.key_lt    = (rdata_reg.key < key_reg);
    assign sts.key_eq    = (rdata_reg.key == key_reg);
    assign sts.id_eq     = (rdata_reg.id == id_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_key     = m_rec_reg.key;
    assign m_out_id      = m_rec_reg.id;
    assign m_entry_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("record count above depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("memory write beyond the stored records");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transaction");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.cnt_op == CNT_INC) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("count did not advance on insert");

endmodule

// File: rtl/core/srt_ctrl.sv
// controller state machine of the sorted record table
module srt_ctrl
    import srt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_e state_reg;
    state_e state_next;
    logic   ins_move;

    assign ins_move = sts.ptr_first ? (!sts.key_lt && !sts.key_eq) : !sts.key_lt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.cmd)
                    CMD_INSERT: begin
                        if (sts.cnt_full) begin
                            state_next = S_DONE;
                        end else if (sts.cnt_zero) begin
                            state_next = S_INS_PUT;
                        end else begin
                            state_next = S_INS_WALK;
                        end
                    end
                    CMD_REMOVE: state_next = sts.cnt_zero ? S_DONE : S_RM_WALK;
                    CMD_SEARCH, CMD_NEXT, CMD_PREV: state_next = sts.cnt_zero ? S_DONE : S_FIND;
                    CMD_MIN, CMD_MAX: state_next = sts.cnt_zero ? S_DONE : S_FETCH;
                    default: state_next = S_DONE;
                endcase
            end
            S_INS_WALK: begin
                if (!ins_move) begin
                    state_next = S_DONE;
                end else if (sts.ptr_first) begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: state_next = S_DONE;
            S_RM_WALK: begin
                if (sts.key_lt) begin
                    if (sts.ptr_last) begin
                        state_next = S_DONE;
                    end
                end else if (sts.key_eq) begin
                    state_next = sts.ptr_last ? S_DONE : S_RM_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RM_SHIFT: begin
                if (sts.ptr_last) begin
                    state_next = S_DONE;
                end
            end
            S_FIND: begin
                if (sts.id_eq) begin
                    if (sts.cmd == CMD_NEXT && !sts.ptr_last) begin
                        state_next = S_FETCH;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (sts.ptr_last) begin
                    state_next = S_DONE;
                end
            end
            S_FETCH: state_next = S_DONE;
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        ctl.ptr_op    = PTR_HOLD;
        ctl.wr_en     = 1'b0;
        ctl.wr_addr   = WA_PTR;
        ctl.wr_src    = WS_RDATA;
        ctl.res_op    = RES_HOLD;
        ctl.status    = ST_OK;
        ctl.prev_load = 1'b0;
        ctl.cnt_op    = CNT_HOLD;
        ctl.cmd_load  = 1'b0;
        ctl.out_load  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                ctl.cmd_load = s_valid;
            end
            S_DISPATCH: begin
                case (sts.cmd)
                    CMD_INSERT: begin
                        if (sts.cnt_full) begin
                            ctl.res_op = RES_ZERO;
                            ctl.status = ST_FULL;
                        end else if (sts.cnt_zero) begin
                            ctl.ptr_op = PTR_ZERO;
                        end else begin
                            ctl.ptr_op = PTR_LAST;
                        end
                    end
                    CMD_REMOVE, CMD_MIN: begin
                        if (sts.cnt_zero) begin
                            ctl.res_op = RES_ZERO;
                            ctl.status = ST_EMPTY;
                        end else begin
                            ctl.ptr_op = PTR_ZERO;
                        end
                    end
                    CMD_MAX: begin
                        if (sts.cnt_zero) begin
                            ctl.res_op = RES_ZERO;
                            ctl.status = ST_EMPTY;
                        end else begin
                            ctl.ptr_op = PTR_LAST;
                        end
                    end
                    CMD_SEARCH, CMD_NEXT, CMD_PREV: begin
                        if (sts.cnt_zero) begin
                            ctl.res_op = RES_ZERO;
                            ctl.status = ST_NOT_FOUND;
                        end else begin
                            ctl.ptr_op = PTR_ZERO;
                        end
                    end
                    default: begin
                        ctl.cnt_op = CNT_CLR;
                        ctl.res_op = RES_ZERO;
                        ctl.status = ST_OK;
                    end
                endcase
            end
            S_INS_WALK: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = WA_PLUS;
                if (ins_move) begin
                    ctl.wr_src = WS_RDATA;
                    ctl.ptr_op = sts.ptr_first ? PTR_HOLD : PTR_DEC;
                end else begin
                    ctl.wr_src = WS_NEW;
                    ctl.res_op = RES_NEW;
                    ctl.status = ST_OK;
                    ctl.cnt_op = CNT_INC;
                end
            end
            S_INS_PUT: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = WA_PTR;
                ctl.wr_src  = WS_NEW;
                ctl.res_op  = RES_NEW;
                ctl.status  = ST_OK;
                ctl.cnt_op  = CNT_INC;
            end
            S_RM_WALK: begin
                if (sts.key_lt) begin
                    if (sts.ptr_last) begin
                        ctl.res_op = RES_ZERO;
                        ctl.status = ST_NOT_FOUND;
                    end else begin
                        ctl.ptr_op = PTR_INC;
                    end
                end else if (sts.key_eq) begin
                    ctl.res_op = RES_RDATA;
                    ctl.status = ST_OK;
                    if (sts.ptr_last) begin
                        ctl.cnt_op = CNT_DEC;
                    end else begin
                        ctl.ptr_op = PTR_INC;
                    end
                end else begin
                    ctl.res_op = RES_ZERO;
                    ctl.status = ST_NOT_FOUND;
                end
            end
            S_RM_SHIFT: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = WA_MINUS;
                ctl.wr_src  = WS_RDATA;
                if (sts.ptr_last) begin
                    ctl.cnt_op = CNT_DEC;
                end else begin
                    ctl.ptr_op = PTR_INC;
                end
            end
            S_FIND: begin
                if (sts.id_eq) begin
                    case (sts.cmd)
                        CMD_NEXT: begin
                            if (sts.ptr_last) begin
                                ctl.res_op = RES_ZERO;
                                ctl.status = ST_NO_NEIGHBOR;
                            end else begin
                                ctl.ptr_op = PTR_INC;
                            end
                        end
                        CMD_PREV: begin
                            if (sts.ptr_first) begin
                                ctl.res_op = RES_ZERO;
                                ctl.status = ST_NO_NEIGHBOR;
                            end else begin
                                ctl.res_op = RES_PREV;
                                ctl.status = ST_OK;
                            end
                        end
                        default: begin
                            ctl.res_op = RES_RDATA;
                            ctl.status = ST_OK;
                        end
                    endcase
                end else if (sts.ptr_last) begin
                    ctl.res_op = RES_ZERO;
                    ctl.status = ST_NOT_FOUND;
                end else begin
                    ctl.prev_load = 1'b1;
                    ctl.ptr_op    = PTR_INC;
                end
            end
            S_FETCH: begin
                ctl.res_op = RES_RDATA;
                ctl.status = ST_OK;
            end
            S_DONE: begin
                ctl.out_load = sts.out_free;
            end
            default: begin
                ctl.ptr_op = PTR_HOLD;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted transaction not dispatched");

    a_write_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |-> (state_reg == S_INS_WALK || state_reg == S_INS_PUT
                       || state_reg == S_RM_SHIFT))
        else $error("memory write outside insert or remove");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |=> (state_reg == S_IDLE))
        else $error("result loaded without return to idle");

endmodule

// File: rtl/core/sorted_record_table.sv
// top level of the sorted record table
//
// keeps up to DEPTH records (id, key) in ascending key order in one
// single-port-write, registered-read memory
// input channel s_*: one command per transaction (insert, remove by key,
// search id, min, max, next, previous, clear) with s_rec_id and s_rec_key
// result channel m_*: one transaction per command with status, key, id
// and the record count after the command
// a command passes from idle through dispatch and any walk or fetch to the
// done state, with one memory read per cycle of the walk (insert walks
// down from the top and shifts as it goes, remove finds the key and
// shifts the tail down, id lookups scan from the front)
// one command is in flight at a time; s_ready is high only when idle
// the result waits in an output register; when the receiver stalls the
// next command may be accepted but its result is held back until the
// earlier one is taken
// reset clears the record count and the output valid; memory contents
// are left as they are and are never used before being written
module sorted_record_table
    import srt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [ID_W-1:0]     s_rec_id,
    input  logic [KEY_W-1:0]    s_rec_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [ID_W-1:0]     m_out_id,
    output logic [CNT_W-1:0]    m_entry_count
);

    ctl_t ctl;
    sts_t sts;

    srt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    srt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_cmd         (s_cmd),
        .s_rec_id      (s_rec_id),
        .s_rec_key     (s_rec_key),
        .ctl           (ctl),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_id      (m_out_id),
        .m_entry_count (m_entry_count)
    );

endmodule

// File: verif/sorted_record_table_tb.sv
// self-checking testbench of the sorted record table: directed table, then random command runs
module sorted_record_table_tb;
    import srt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH   = DEPTH_DEF;
    localparam int TOTAL_ITEMS = 1450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 2 * (TBL_DEPTH + 4);

    typedef struct packed {
        status_e          status;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
    } table_result_t;

    typedef struct packed {
        cmd_e             cmd;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
        logic             typed;
        table_result_t    res;
    } directed_row_t;

    typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_e;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd;
    logic [ID_W-1:0]     s_rec_id;
    logic [KEY_W-1:0]    s_rec_key;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [KEY_W-1:0]    m_out_key;
    logic [ID_W-1:0]     m_out_id;
    logic [CNT_W-1:0]    m_entry_count;

    logic [KEY_W-1:0] tbl_key [TBL_DEPTH];
    logic [ID_W-1:0]  tbl_id [TBL_DEPTH];
    int               tbl_count = 0;

    table_result_t pending_results[$];
    int            errors = 0;
    int            cycle_cnt = 0;
    int            accepted_cnt = 0;
    bit            no_gap = 1'b0;
    bit            pressure_done = 1'b0;

    sorted_record_table #(
        .DEPTH(TBL_DEPTH)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_rec_id(s_rec_id),
        .s_rec_key(s_rec_key),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_out_key(m_out_key),
        .m_out_id(m_out_id),
        .m_entry_count(m_entry_count)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // applies one command to the table copy and returns its result
    function automatic table_result_t apply_table_cmd(cmd_e c, logic [ID_W-1:0] id,
                                                      logic [KEY_W-1:0] key);
        table_result_t r;
        int            pos;
        int            hit;
        r.status = ST_OK;
        r.key    = '0;
        r.id     = '0;
        hit      = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_id[i] == id) begin
                hit = i;
            end
        end
        case (c)
            CMD_INSERT: begin
                if (tbl_count >= TBL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // an equal head record stays in front
                    if (tbl_count == 0 || tbl_key[0] > key) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < tbl_count && tbl_key[pos] < key) pos++;
                    end
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_id[i]  = tbl_id[i-1];
                    end
                    tbl_key[pos] = key;
                    tbl_id[pos]  = id;
                    tbl_count++;
                    r.key = key;
                    r.id  = id;
                end
            end
            CMD_REMOVE: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < tbl_count && tbl_key[pos] < key) pos++;
                    if (pos >= tbl_count || tbl_key[pos] != key) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.key = tbl_key[pos];
                        r.id  = tbl_id[pos];
                        for (int i = pos; i + 1 < tbl_count; i++) begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_id[i]  = tbl_id[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
            CMD_SEARCH: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.key = tbl_key[hit];
                    r.id  = tbl_id[hit];
                end
            end
            CMD_MIN, CMD_MAX: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos   = (c == CMD_MIN) ? 0 : tbl_count - 1;
                    r.key = tbl_key[pos];
                    r.id  = tbl_id[pos];
                end
            end
            CMD_NEXT: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (hit + 1 >= tbl_count) begin
                    r.status = ST_NO_NEIGHBOR;
                end else begin
                    r.key = tbl_key[hit+1];
                    r.id  = tbl_id[hit+1];
                end
            end
            CMD_PREV: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (hit == 0) begin
                    r.status = ST_NO_NEIGHBOR;
                end else begin
                    r.key = tbl_key[hit-1];
                    r.id  = tbl_id[hit-1];
                end
            end
            default: begin
                tbl_count = 0;
            end
        endcase
        r.count = CNT_W'(tbl_count);
        return r;
    endfunction

    function automatic directed_row_t dir_row(cmd_e c, logic [ID_W-1:0] id,
                                              logic [KEY_W-1:0] key, logic typed,
                                              status_e st, logic [KEY_W-1:0] k,
                                              logic [ID_W-1:0] i, logic [CNT_W-1:0] n);
        directed_row_t row;
        row.cmd        = c;
        row.id         = id;
        row.key        = key;
        row.typed      = typed;
        row.res.status = st;
        row.res.key    = k;
        row.res.id     = i;
        row.res.count  = n;
        return row;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && tbl_count > 0) return tbl_id[$urandom_range(0, tbl_count - 1)];
        if (r < 7) return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit present);
        int r;
        r = $urandom_range(0, 9);
        if (tbl_count > 0 && ((present && r < 9) || r < 2)) begin
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        end
        if (r < 6) return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom_range(0, 255));
    endfunction

    task automatic send_cmd(cmd_e c, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                            logic typed, table_result_t typed_res);
        table_result_t predicted;
        int            gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= c;
        s_rec_id  <= id;
        s_rec_key <= key;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_table_cmd(c, id, key);
        pending_results.push_back(typed ? typed_res : predicted);
        accepted_cnt++;
    endtask

    // result channel checker
    always @(posedge aclk) begin
        table_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction status %0d key %0h id %0h count %0d",
                         $time, m_status, m_out_key, m_out_id, m_entry_count);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, m_status);
                    errors++;
                end
                if (m_out_key !== exp_res.key) begin
                    $display("%0t: out_key expected %0h actual %0h",
                             $time, exp_res.key, m_out_key);
                    errors++;
                end
                if (m_out_id !== exp_res.id) begin
                    $display("%0t: out_id expected %0h actual %0h",
                             $time, exp_res.id, m_out_id);
                    errors++;
                end
                if (m_entry_count !== exp_res.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_res.count, m_entry_count);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin : result_sink
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (!pressure_done && accepted_cnt >= 60) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                pressure_done = 1'b1;
            end
            hold = ((cycle_cnt % 2000) < 300) ? 0 : pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        directed_row_t dir_rows[$];
        table_result_t blank;
        run_e          run_mode;
        int            run_left;
        int            r;
        cmd_e          c;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cmd     = CMD_INSERT;
        s_rec_id  = '0;
        s_rec_key = '0;
        m_ready   = 1'b0;
        blank     = '0;
        run_mode  = RUN_MIXED;
        run_left  = 0;

        dir_rows = '{
            dir_row(CMD_MIN,    31'd0,          8'h00, 1, ST_EMPTY,       8'h00, 31'd0, 5'd0),
            dir_row(CMD_MAX,    31'd0,          8'h00, 1, ST_EMPTY,       8'h00, 31'd0, 5'd0),
            dir_row(CMD_REMOVE, 31'd0,          8'hFF, 1, ST_EMPTY,       8'h00, 31'd0, 5'd0),
            dir_row(CMD_SEARCH, 31'h7FFFFFFF,   8'h00, 1, ST_NOT_FOUND,   8'h00, 31'd0, 5'd0),
            dir_row(CMD_NEXT,   31'd0,          8'h00, 1, ST_NOT_FOUND,   8'h00, 31'd0, 5'd0),
            dir_row(CMD_PREV,   31'd1,          8'h00, 1, ST_NOT_FOUND,   8'h00, 31'd0, 5'd0),
            dir_row(CMD_INSERT, 31'h7FFFFFFF,   8'hFF, 1, ST_OK, 8'hFF, 31'h7FFFFFFF, 5'd1),
            dir_row(CMD_INSERT, 31'd0,          8'h00, 1, ST_OK,          8'h00, 31'd0, 5'd2),
            // equal head key: goes behind the head record
            dir_row(CMD_INSERT, 31'h2AAAAAAA,   8'h00, 1, ST_OK, 8'h00, 31'h2AAAAAAA, 5'd3),
            dir_row(CMD_INSERT, 31'h55555555,   8'h55, 1, ST_OK, 8'h55, 31'h55555555, 5'd4),
            dir_row(CMD_PREV,   31'd0,          8'h00, 1, ST_NO_NEIGHBOR, 8'h00, 31'd0, 5'd4),
            dir_row(CMD_NEXT,   31'h7FFFFFFF,   8'h00, 1, ST_NO_NEIGHBOR, 8'h00, 31'd0, 5'd4),
            dir_row(CMD_NEXT,   31'd0,          8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_PREV,   31'h7FFFFFFF,   8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_SEARCH, 31'h55555555,   8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_MIN,    31'd0,          8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_MAX,    31'd0,          8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_REMOVE, 31'd0,          8'h10, 1, ST_NOT_FOUND,   8'h00, 31'd0, 5'd4),
            dir_row(CMD_REMOVE, 31'd0,          8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            // duplicate id: lookups take the one nearest the minimum
            dir_row(CMD_INSERT, 31'h2AAAAAAA,   8'hAA, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_SEARCH, 31'h2AAAAAAA,   8'h00, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_REMOVE, 31'd0,          8'hFF, 0, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_CLEAR,  31'h7FFFFFFF,   8'hFF, 1, ST_OK,          8'h00, 31'd0, 5'd0),
            dir_row(CMD_MIN,    31'd0,          8'h00, 1, ST_EMPTY,       8'h00, 31'd0, 5'd0),
            dir_row(CMD_INSERT, 31'd1,          8'h80, 0, ST_OK,          8'h00, 31'd0, 5'd0)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[n]) begin
            send_cmd(dir_rows[n].cmd, dir_rows[n].id, dir_rows[n].key,
                     dir_rows[n].typed, dir_rows[n].res);
        end

        // runs of fills to full, drains towards empty, and mixed traffic
        while (accepted_cnt < TOTAL_ITEMS) begin
            if (run_left == 0) begin
                r      = $urandom_range(0, 9);
                no_gap = ($urandom_range(0, 4) == 0);
                if (r < 2) begin
                    run_mode = RUN_FILL;
                    run_left = TBL_DEPTH - tbl_count + $urandom_range(1, 3);
                end else if (r < 3) begin
                    run_mode = RUN_DRAIN;
                    run_left = tbl_count + $urandom_range(1, 2);
                end else begin
                    run_mode = RUN_MIXED;
                    run_left = $urandom_range(10, 40);
                end
            end
            case (run_mode)
                RUN_FILL:  c = CMD_INSERT;
                RUN_DRAIN: c = CMD_REMOVE;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 30)      c = CMD_INSERT;
                    else if (r < 50) c = CMD_REMOVE;
                    else if (r < 60) c = CMD_SEARCH;
                    else if (r < 66) c = CMD_MIN;
                    else if (r < 72) c = CMD_MAX;
                    else if (r < 84) c = CMD_NEXT;
                    else if (r < 97) c = CMD_PREV;
                    else             c = CMD_CLEAR;
                end
            endcase
            send_cmd(c, pick_id(), pick_key(run_mode == RUN_DRAIN), 1'b0, blank);
            run_left--;
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/srt_pkg.sv
rtl/core/srt_dp.sv
rtl/core/srt_ctrl.sv
rtl/core/sorted_record_table.sv
verif/sorted_record_table_tb.sv
